FILE: src/assert_macros.svh
// assertion macros used by the checker file lfsp_checker
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define LFSP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LFSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/lfsp_pkg.sv
// shared types and codes for the lifo free list slot pool
// used by lfsp_ctrl, lfsp_datapath and the top level
package lfsp_pkg;

	localparam logic ACT_ACQUIRE = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_POP
	} lfsp_state_t;

	typedef struct packed {
		logic init_wr;
		logic take;
		logic pop;
	} lfsp_cmd_t;

	typedef struct packed {
		logic init_last;
		logic res_full;
		logic pop_needed;
	} lfsp_stat_t;

endpackage

FILE: src/lfsp_ctrl.sv
// controller state machine: link memory init sweep, accept, head advance
// depends on lfsp_pkg
module lfsp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  lfsp_pkg::lfsp_stat_t   stat,
	output lfsp_pkg::lfsp_cmd_t    cmd
);

	lfsp_pkg::lfsp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfsp_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lfsp_pkg::ST_INIT: begin
				if (stat.init_last) begin
					state_d = lfsp_pkg::ST_IDLE;
				end
			end
			lfsp_pkg::ST_IDLE: begin
				if (in_valid && !stat.res_full && stat.pop_needed) begin
					state_d = lfsp_pkg::ST_POP;
				end
			end
			lfsp_pkg::ST_POP: begin
				state_d = lfsp_pkg::ST_IDLE;
			end
			default: begin
				state_d = lfsp_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.init_wr = 1'b0;
		cmd.pop     = 1'b0;
		unique case (state_q)
			lfsp_pkg::ST_INIT: begin
				cmd.init_wr = 1'b1;
			end
			lfsp_pkg::ST_IDLE: begin
				in_ready = !stat.res_full;
			end
			lfsp_pkg::ST_POP: begin
				cmd.pop = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.take = in_valid && in_ready;
	end

endmodule

FILE: src/lfsp_datapath.sv
// datapath: free list head, link memory and two-entry result queue
// depends on lfsp_pkg
module lfsp_datapath #(
	parameter int SLOTS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lfsp_pkg::lfsp_cmd_t    cmd,
	output lfsp_pkg::lfsp_stat_t   stat,
	input  logic                   action,
	input  logic [5:0]             slot_index,
	input  logic                   release_null,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   granted,
	output logic [5:0]             given_slot
);

	localparam int HW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(SLOTS + 1);
	localparam logic [LW-1:0] END_LINK = LW'(SLOTS);

	logic [LW-1:0] link_mem [SLOTS];
	logic [LW-1:0] rd_link_q;
	logic [HW-1:0] head_q;
	logic          empty_q;
	logic [HW-1:0] init_cnt_q;
	logic [LW-1:0] init_link;

	logic          slot_ok;
	logic          rel_write;
	logic [HW-1:0] rel_slot;
	logic [LW-1:0] rel_link;

	logic          res_granted_q [2];
	logic [5:0]    res_slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push_res;
	logic          pop_res;
	logic          push_granted;
	logic [5:0]    push_slot;

	assign slot_ok   = int'(slot_index) < SLOTS;
	assign rel_slot  = HW'(slot_index);
	assign rel_write = cmd.take && (action == lfsp_pkg::ACT_RELEASE) && !release_null && slot_ok;
	assign rel_link  = empty_q ? END_LINK : LW'(head_q);
	assign init_link = (init_cnt_q == '0) ? END_LINK : (LW'(init_cnt_q) - LW'(1));

	// link memory, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.init_wr) begin
			link_mem[init_cnt_q] <= init_link;
		end else if (rel_write) begin
			link_mem[rel_slot] <= rel_link;
		end
		rd_link_q <= link_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q <= '0;
		end else if (cmd.init_wr && !stat.init_last) begin
			init_cnt_q <= init_cnt_q + HW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= HW'(SLOTS - 1);
			empty_q <= 1'b0;
		end else if (cmd.pop) begin
			if (rd_link_q >= END_LINK) begin
				empty_q <= 1'b1;
			end else begin
				head_q <= HW'(rd_link_q);
			end
		end else if (rel_write) begin
			head_q  <= rel_slot;
			empty_q <= 1'b0;
		end
	end

	// result queue
	assign push_res     = cmd.take;
	assign pop_res      = out_valid && out_ready;
	assign push_granted = (action == lfsp_pkg::ACT_RELEASE) || !empty_q;
	assign push_slot    = ((action == lfsp_pkg::ACT_ACQUIRE) && !empty_q) ? 6'(head_q) : 6'd0;

	always_ff @(posedge clk) begin
		if (push_res) begin
			res_granted_q[wr_ptr_q] <= push_granted;
			res_slot_q[wr_ptr_q]    <= push_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_res) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_res) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push_res, pop_res})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign out_valid  = cnt_q != 2'd0;
	assign granted    = res_granted_q[rd_ptr_q];
	assign given_slot = res_slot_q[rd_ptr_q];

	assign stat.init_last  = init_cnt_q == HW'(SLOTS - 1);
	assign stat.res_full   = cnt_q == 2'd2;
	assign stat.pop_needed = (action == lfsp_pkg::ACT_ACQUIRE) && !empty_q;

endmodule

FILE: src/lifo_free_list_slot_pool_unit.sv
// a result is offered in the cycle after its input transfer unless an older one waits;
// a two-entry result queue decouples the output, and no request is taken while full
// a release or an exhausted acquire leaves the controller idle for the next
// request; an acquire that gets a slot passes a pop state that takes no request,
// as the registered read of the link memory comes before the head can advance
// reset: async, active low; a link memory init sweep follows, taking no input
module lifo_free_list_slot_pool_unit #(
	parameter int SLOTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [5:0] slot_index,
	input  logic       release_null,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       granted,
	output logic [5:0] given_slot
);

	lfsp_pkg::lfsp_cmd_t  cmd;
	lfsp_pkg::lfsp_stat_t stat;

	lfsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lfsp_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.slot_index   (slot_index),
		.release_null (release_null),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.granted      (granted),
		.given_slot   (given_slot)
	);

endmodule

FILE: src/lfsp_checker.sv
// port-level checks for the lifo free list slot pool, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module lfsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       granted,
	input logic [5:0] given_slot
);

	logic in_xfer;
	logic out_stall;

	assign in_xfer   = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;

	// every input transfer leaves a result pending on the next cycle
	`LFSP_ASSERT(a_result_follows, clk, arst_n, in_xfer |=> out_valid, "no result after transfer")

	// nothing taken or offered while in reset
	`LFSP_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> (!in_ready && !out_valid), "reset activity")

	`LFSP_ASSERT(a_out_hold, clk, arst_n, out_stall |=> out_valid, "result dropped while stalled")

	`LFSP_ASSERT(a_out_stable, clk, arst_n, out_stall |=> $stable({granted, given_slot}), "result moved")

endmodule

bind lifo_free_list_slot_pool_unit lfsp_checker u_lfsp_checker (.*);

FILE: sim/tb_lifo_free_list_slot_pool_unit.sv
`timescale 1ns / 1ps
// testbench for lifo_free_list_slot_pool_unit: tracks the linked free list and
// checks every grant; depends on lfsp_pkg and the top module of the slot pool
module tb_lifo_free_list_slot_pool_unit;

	localparam int SLOTS = 64;
	localparam logic [6:0] LINK_END = 7'(SLOTS);
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic       act;
		logic [5:0] slot;
		logic       nul;
	} pool_req_t;

	typedef struct packed {
		logic       granted;
		logic [5:0] slot;
	} pool_grant_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	pool_req_t  cur_req = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       granted;
	logic [5:0] given_slot;

	logic       in_taken = 1'b0;
	int         send_idle = 13;
	int         recv_idle = 78;
	int         queued_cnt = 0;
	int         accepted_cnt = 0;
	int         fail_cnt = 0;
	int         cycle_cnt = 0;

	pool_req_t   pending_reqs[$];
	pool_grant_t expected_grants[$];

	// free slots and handed-out slots as a well-behaved user sees them
	logic [5:0] free_stack[$];
	logic [5:0] held_slots[$];

	// linked free list as the block keeps it
	logic [6:0] pool_head;
	logic       pool_empty;
	logic [6:0] link_mem[SLOTS];

	lifo_free_list_slot_pool_unit #(.SLOTS(SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(cur_req.act),
		.slot_index(cur_req.slot),
		.release_null(cur_req.nul),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.granted(granted),
		.given_slot(given_slot)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic pool_grant_t predict_grant(pool_req_t r);
		pool_grant_t g;
		logic [6:0]  nxt;
		g = '0;
		if (r.act == lfsp_pkg::ACT_ACQUIRE) begin
			if (!pool_empty && pool_head < SLOTS) begin
				g.granted = 1'b1;
				g.slot = pool_head[5:0];
				nxt = link_mem[pool_head[5:0]];
				if (nxt >= LINK_END)
					pool_empty = 1'b1;
				else
					pool_head = nxt;
			end
		end else begin
			g.granted = 1'b1;
			if (!r.nul && r.slot < SLOTS) begin
				link_mem[r.slot] = pool_empty ? LINK_END : pool_head;
				pool_head = {1'b0, r.slot};
				pool_empty = 1'b0;
			end
		end
		return g;
	endfunction

	function automatic void queue_req(logic act, logic [5:0] slot, logic nul);
		pool_req_t r;
		r.act = act;
		r.slot = slot;
		r.nul = nul;
		pending_reqs.push_back(r);
		queued_cnt++;
	endfunction

	function automatic void add_acquire(logic [5:0] junk_slot, logic junk_null);
		if (free_stack.size() != 0)
			held_slots.push_back(free_stack.pop_back());
		queue_req(lfsp_pkg::ACT_ACQUIRE, junk_slot, junk_null);
	endfunction

	function automatic void add_release(int k);
		logic [5:0] s;
		s = held_slots[k];
		held_slots.delete(k);
		free_stack.push_back(s);
		queue_req(lfsp_pkg::ACT_RELEASE, s, 1'b0);
	endfunction

	// runs of acquire-heavy, balanced and release-heavy traffic
	task automatic fill_well_formed(int n);
		int stop;
		int pct;
		int run;
		stop = queued_cnt + n;
		while (queued_cnt < stop) begin
			case ($urandom_range(2))
				0: pct = 90;
				1: pct = 50;
				default: pct = 12;
			endcase
			run = $urandom_range(90, 20);
			repeat (run) begin
				if ($urandom_range(99) < pct)
					add_acquire(6'($urandom), 1'($urandom));
				else if (held_slots.size() == 0 || $urandom_range(7) == 0)
					queue_req(lfsp_pkg::ACT_RELEASE, 6'($urandom), 1'b1);
				else
					add_release($urandom_range(held_slots.size() - 1));
			end
		end
	endtask

	task automatic wait_all_done();
		do
			@(negedge clk);
		while (accepted_cnt != queued_cnt || expected_grants.size() != 0);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
					cur_req <= pending_reqs.pop_front();
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
			out_ready <= $urandom_range(99) >= recv_idle;
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		pool_grant_t want;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (expected_grants.size() == 0) begin
					$display("%0t: unexpected transfer, expected none, actual granted %0b slot %0d",
						$time, granted, given_slot);
					fail_cnt++;
				end else begin
					want = expected_grants.pop_front();
					if (granted !== want.granted) begin
						$display("%0t: granted expected %0b actual %0b",
							$time, want.granted, granted);
						fail_cnt++;
					end
					if (given_slot !== want.slot) begin
						$display("%0t: given_slot expected %0d actual %0d",
							$time, want.slot, given_slot);
						fail_cnt++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_grants.push_back(predict_grant(cur_req));
				accepted_cnt++;
			end
		end else
			in_taken <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [5:0] s;
		pool_head = 7'(SLOTS - 1);
		pool_empty = 1'b0;
		link_mem[0] = LINK_END;
		for (int i = 1; i < SLOTS; i++)
			link_mem[i] = 7'(i - 1);
		for (int i = 0; i < SLOTS; i++)
			free_stack.push_back(6'(i));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ignored fields at their extremes on acquire
		add_acquire(6'h3F, 1'b1);
		add_acquire(6'h00, 1'b0);
		add_acquire(6'h2A, 1'b1);
		// null releases, then releases and acquires of held slots
		queue_req(lfsp_pkg::ACT_RELEASE, 6'd0, 1'b1);
		queue_req(lfsp_pkg::ACT_RELEASE, 6'd63, 1'b1);
		add_release(0);
		add_release(1);
		add_acquire(6'h15, 1'b0);
		add_acquire(6'h3F, 1'b0);
		repeat (3) add_release(0);

		// drain down to slot 0, then exhausted acquires
		while (free_stack.size() != 0)
			add_acquire(6'($urandom), 1'($urandom));
		add_acquire(6'($urandom), 1'($urandom));
		add_acquire(6'($urandom), 1'($urandom));
		// release onto an empty list, pop it again as the last element
		add_release(held_slots.size() - 1);
		add_acquire(6'($urandom), 1'($urandom));
		add_acquire(6'($urandom), 1'($urandom));
		fill_well_formed(180);
		wait_all_done();

		@(posedge clk);
		send_idle = 78;
		recv_idle = 13;
		fill_well_formed(270);
		wait_all_done();

		@(posedge clk);
		send_idle = 0;
		recv_idle = 0;
		fill_well_formed(150);
		// double release, then unrestricted traffic
		if (held_slots.size() == 0)
			add_acquire(6'($urandom), 1'($urandom));
		s = held_slots[0];
		add_release(0);
		queue_req(lfsp_pkg::ACT_RELEASE, s, 1'b0);
		repeat (110)
			queue_req($urandom_range(1) ? lfsp_pkg::ACT_RELEASE : lfsp_pkg::ACT_ACQUIRE,
				6'($urandom), $urandom_range(3) == 0);
		wait_all_done();

		repeat (10) @(posedge clk);
		@(negedge clk);
		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/lfsp_pkg.sv
src/lfsp_ctrl.sv
src/lfsp_datapath.sv
src/lifo_free_list_slot_pool_unit.sv
src/lfsp_checker.sv
sim/tb_lifo_free_list_slot_pool_unit.sv
